>>> hdl/jch_pkg.sv
// Package for the jump consistent hash block.
// Holds constants, register map and unit request/response types.
// No dependencies.
package jch_pkg;

  localparam logic [63:0] LCG_MULT         = 64'd2862933555777941757;
  localparam int          JUMP_SCALE_SHIFT = 31;
  localparam int          KEY_TOP_SHIFT    = 33;

  localparam int MUL_DIGIT_W = 16;
  localparam int MUL_STEPS   = 64 / MUL_DIGIT_W;
  localparam int MUL_CNT_W   = $clog2(MUL_STEPS);
  localparam int DIV_STEPS   = 64;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam int          PADDR_W            = 3;
  localparam logic        REG_BUCKET_COUNT   = 1'b0;
  localparam logic [31:0] BUCKET_COUNT_RESET = 32'd1;

  typedef struct packed {
    logic        start;
    logic [63:0] key;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] key;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
  } div_rsp_t;

endpackage

>>> hdl/jump_consistent_hash.sv
// Jump consistent hash bucket selector, top level.
// Depends on jch_pkg, jch_lcg and jch_div.
//
// Input channel: key with in_valid / in_stall. Output channel: bucket with
// out_valid / out_stall. An item moves at a clock edge with valid high and
// stall low. bucket_count is written over the APB port at byte address 0;
// write it only while the block is idle.
// One key at a time: in_stall is high from acceptance until the result is
// moved into the output register. Each loop pass runs one LCG step on the
// 16-bit digit multiplier and then one 64/32 restoring division; the number
// of passes is about ln(bucket_count) + 1. A zero count skips the loop.
// The output register lets the next key be taken while a result waits; a
// stalled receiver holds the finished result in the sequencer until the
// register frees.
// Synchronous reset clears the sequencer, both units and out_valid, and
// sets bucket_count to 1.
module jump_consistent_hash
  import jch_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [63:0]        key,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        bucket,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]  state;
  logic [1:0]  state_next;
  logic [31:0] bucket_count;
  logic [63:0] key_w;
  logic [31:0] b;
  logic [32:0] b_inc;
  logic        in_acc;
  logic        out_free;
  logic        more;
  mul_req_t    mul_req;
  mul_rsp_t    mul_rsp;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BUCKET_COUNT) ? bucket_count : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BUCKET_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_BUCKET_COUNT) begin
      bucket_count <= pwdata;
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign more     = (div_rsp.quot < {32'd0, bucket_count});
  assign b_inc    = {1'b0, b} + 33'd1;

  jch_lcg u_lcg (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  jch_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    state_next    = state;
    mul_req.start = 1'b0;
    mul_req.key   = key_w;
    div_req.start = 1'b0;
    div_req.num   = 64'(b_inc) << JUMP_SCALE_SHIFT;
    div_req.den   = 32'(mul_rsp.key >> KEY_TOP_SHIFT) + 32'd1;
    unique case (state)
      ST_IDLE: begin
        mul_req.key = key;
        if (in_acc) begin
          if (bucket_count == 32'd0) begin
            state_next = ST_DONE;
          end else begin
            mul_req.start = 1'b1;
            state_next    = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (mul_rsp.done) begin
          div_req.start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          if (more) begin
            mul_req.start = 1'b1;
            state_next    = ST_MUL;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b <= 32'd0;
    end else if (state == ST_DIV && div_rsp.done && more) begin
      b <= div_rsp.quot[31:0];
    end
    if (state == ST_MUL && mul_rsp.done) begin
      key_w <= mul_rsp.key;
    end else if (in_acc) begin
      key_w <= key;
    end
    if (state == ST_DONE && out_free) begin
      bucket <= b;
    end
  end

  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    mul_rsp.done |-> state == ST_MUL)
    else $error("multiplier finished outside the multiply step");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == ST_DIV)
    else $error("divider finished outside the divide step");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == ST_MUL || state == ST_DONE))
    else $error("accepted item did not start a pass");

  a_done_loads_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |=> (out_valid && state == ST_IDLE))
    else $error("finished result not moved to the output register");

endmodule

>>> hdl/jch_lcg.sv
// Iterative LCG step: key * LCG_MULT + 1 mod 2^64, one 16-bit digit a cycle.
// Depends on jch_pkg.
module jch_lcg
  import jch_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [MUL_CNT_W-1:0] cnt;
  logic [63:0]          a_sh;
  logic [63:0]          m_sh;
  logic [63:0]          acc;
  logic [63:0]          acc_next;
  logic [MUL_DIGIT_W+63:0] partial;

  assign partial  = a_sh[MUL_DIGIT_W-1:0] * m_sh;
  assign acc_next = acc + partial[63:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= MUL_CNT_W'(MUL_STEPS - 1);
        a_sh <= req.key;
        m_sh <= LCG_MULT;
        acc  <= 64'd1;
      end else if (busy) begin
        acc  <= acc_next;
        a_sh <= a_sh >> MUL_DIGIT_W;
        m_sh <= m_sh << MUL_DIGIT_W;
        cnt  <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = {done, acc};

endmodule

>>> hdl/jch_div.sv
// Restoring divider, 64-bit numerator by 32-bit divisor, one bit a cycle.
// Depends on jch_pkg.
module jch_div
  import jch_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [63:0]          nq;
  logic [31:0]          den;
  logic [31:0]          rem;
  logic [32:0]          rem_sh;
  logic [32:0]          diff;
  logic                 qbit;

  assign rem_sh = {rem, nq[63]};
  assign diff   = rem_sh - {1'b0, den};
  assign qbit   = ~diff[32];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
        nq   <= req.num;
        den  <= req.den;
        rem  <= '0;
      end else if (busy) begin
        rem <= qbit ? diff[31:0] : rem_sh[31:0];
        nq  <= {nq[62:0], qbit};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = {done, nq};

endmodule

>>> tb/tb_top.sv
// Testbench for jump_consistent_hash: random and edge keys over a range of bucket counts,
// checked against an in-bench jump hash predictor. Needs jch_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
  import jch_pkg::*;

  localparam int REG_UNMAPPED = 1; // no register at this index
  localparam int HOLD_CYCLES  = 2500;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [63:0]        key = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [31:0]        bucket;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  logic [63:0] key_q[$];
  logic [31:0] bucket_exp_q[$];
  logic [31:0] cfg_buckets = BUCKET_COUNT_RESET;
  logic [31:0] want;
  bit          no_gaps = 1'b0;
  int          n_errors = 0;
  int          n_results = 0;
  int          n_cfg = 0;
  int          n_holds = 0;
  int          hold_left = 0;
  int          next_hold_at = 500;

  jump_consistent_hash dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .key(key),
    .out_valid(out_valid), .out_stall(out_stall), .bucket(bucket),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] jump_bucket(input logic [63:0] k, input logic [31:0] n);
    logic [63:0] st;
    logic [63:0] last;
    logic [63:0] nxt;
    st = k;
    last = '0;
    nxt = '0;
    while (nxt < {32'd0, n}) begin
      last = nxt;
      st = st * LCG_MULT + 64'd1;
      nxt = ((last + 64'd1) << JUMP_SCALE_SHIFT) / ((st >> KEY_TOP_SHIFT) + 64'd1);
    end
    return last[31:0];
  endfunction

  function automatic logic [63:0] edge_key(input int i);
    case (i)
      0:       return 64'h0000_0000_0000_0000;
      1:       return 64'hFFFF_FFFF_FFFF_FFFF;
      2:       return 64'h0000_0000_0000_0001;
      3:       return 64'h8000_0000_0000_0000;
      4:       return 64'h7FFF_FFFF_FFFF_FFFF;
      5:       return 64'hAAAA_AAAA_AAAA_AAAA;
      6:       return 64'h5555_5555_5555_5555;
      7:       return 64'h0000_0001_0000_0000;
      8:       return 64'hFFFF_FFFF_0000_0000;
      default: return 64'h0000_0000_FFFF_FFFF;
    endcase
  endfunction

  function automatic logic [63:0] rand_key();
    logic [63:0] one_hot;
    one_hot = 64'd1 << $urandom_range(0, 63);
    case ($urandom_range(0, 9))
      0:       return one_hot;
      1:       return ~one_hot;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // sender: a new item may go out once the previous one is taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) bucket_exp_q.push_back(jump_bucket(key, cfg_buckets));
      if (key_q.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 31)) begin
        in_valid <= 1'b1;
        key <= key_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with long hold-offs so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (n_results >= next_hold_at) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      next_hold_at <= next_hold_at + 1000;
      n_holds <= n_holds + 1;
    end else begin
      out_stall <= !no_gaps && ($urandom_range(0, 99) < 31);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (bucket_exp_q.size() == 0) begin
        $error("bucket: no item pending, got %0d", bucket);
        n_errors++;
      end else begin
        want = bucket_exp_q.pop_front();
        if (bucket !== want) begin
          $error("bucket: expected %0d, got %0d", want, bucket);
          n_errors++;
        end
      end
    end
  end

  // checked away from the rising edge so the sender's updates have settled
  task automatic wait_idle();
    @(negedge clk);
    while (key_q.size() != 0 || in_valid || bucket_exp_q.size() != 0) @(negedge clk);
  endtask

  task automatic apb_xfer(input bit wr, input logic [PADDR_W-1:0] a, input logic [31:0] wd,
                          output logic [31:0] rd);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= a;
    pwdata <= wd;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_write(input int idx, input logic [31:0] v);
    logic [31:0] rd;
    wait_idle();
    apb_xfer(1'b1, PADDR_W'(idx * 4), v, rd);
    if (idx == REG_BUCKET_COUNT) cfg_buckets = v;
    n_cfg++;
    apb_xfer(1'b0, PADDR_W'(REG_BUCKET_COUNT * 4), '0, rd);
    if (rd !== cfg_buckets) begin
      $error("bucket_count: expected %0d, got %0d", cfg_buckets, rd);
      n_errors++;
    end
  endtask

  task automatic run_phase(input logic [31:0] n, input int items, input bit quiet);
    cfg_write(REG_BUCKET_COUNT, n);
    no_gaps = quiet;
    repeat (items) key_q.push_back(rand_key());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // edge keys: reset count, zero count, unmapped write, widest count
    for (int i = 0; i < 4; i++) key_q.push_back(edge_key(i));
    cfg_write(REG_BUCKET_COUNT, 32'd0);
    for (int i = 4; i < 8; i++) key_q.push_back(edge_key(i));
    cfg_write(REG_UNMAPPED, 32'd77);
    for (int i = 8; i < 10; i++) key_q.push_back(edge_key(i));
    cfg_write(REG_BUCKET_COUNT, 32'hFFFF_FFFF);
    for (int i = 0; i < 10; i++) key_q.push_back(edge_key(i));

    run_phase(32'd1, 150, 1'b0);
    run_phase(32'd2, 250, 1'b0);
    run_phase(32'd3, 250, 1'b0);
    run_phase(32'd5, 300, 1'b1);
    run_phase(32'd64, 300, 1'b0);
    run_phase(32'd1000, 150, 1'b0);
    run_phase($urandom_range(1, 4000), 150, 1'b0);
    run_phase($urandom_range(1, 4000), 150, 1'b0);
    run_phase(32'h8000_0000, 25, 1'b0);
    run_phase(32'hFFFF_FFFF, 25, 1'b0);
    run_phase($urandom(), 20, 1'b0);
    run_phase(32'd0, 50, 1'b0);
    run_phase($urandom_range(2, 20), 60, 1'b0);

    wait_idle();
    repeat (2000) @(posedge clk);
    if (bucket_exp_q.size() != 0) begin
      $error("bucket: %0d results never arrived", bucket_exp_q.size());
      n_errors++;
    end
    $display("Hashed %0d keys across %0d register writes, bucket counts 0 to 2^32-1,",
             n_results, n_cfg);
    $display("with random stalls on both sides and %0d long output hold-offs.", n_holds);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
